// File: hw/rtl/mpu_pkg.sv
// ----------------------------------------------------------------------------
// mpu_pkg
// Shared types and constants of the MPU region access checker.
// ----------------------------------------------------------------------------
package mpu_pkg;

    localparam int REGION_COUNT = 8;
    localparam int RIDX_W       = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
    localparam int RAM_DEPTH    = 2 * REGION_COUNT;
    localparam int RAM_AW       = $clog2(RAM_DEPTH);
    localparam int WORD_W       = 32;
    localparam int GRAN_LSB     = 5;

    // control register bits
    localparam int CTRL_W          = 3;
    localparam int CTRL_ENABLE_BIT = 0;
    localparam int CTRL_DEFMAP_BIT = 2;

    // region word fields
    localparam int XN_BIT       = 0;
    localparam int AP_LSB       = 1;
    localparam int LIMIT_EN_BIT = 0;

    // configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_CTRL_SECURE    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CTRL_NONSECURE = 1'd1;

    // op codes
    localparam logic OP_CHECK = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // access kinds
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_FETCH = 2'd2;

    // access permission codes
    localparam logic [1:0] AP_PRIV_RW = 2'd0;
    localparam logic [1:0] AP_ALL_RW  = 2'd1;

    typedef struct packed {
        logic              op;
        logic              nonsecure_bank;
        logic [WORD_W-1:0] address;
        logic              privileged;
        logic [1:0]        access_kind;
        logic [2:0]        region_number;
        logic [WORD_W-1:0] base_word;
        logic [WORD_W-1:0] limit_word;
    } mpu_in_word_t;

    typedef struct packed {
        logic              allowed;
        logic              unit_enabled;
        logic              region_hit;
        logic [2:0]        hit_region;
        logic [WORD_W-1:0] matched_base_word;
        logic [WORD_W-1:0] matched_limit_word;
        logic              execute_never;
    } mpu_out_word_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic read;
        logic step;
        logic load_out;
    } mpu_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic start_scan;
        logic match;
        logic last_region;
        logic out_free;
    } mpu_status_t;

endpackage

// File: hw/rtl/mpu_in_if.sv
// ----------------------------------------------------------------------------
// mpu_in_if
// Valid/ready channel carrying one input word of the MPU checker.
// ----------------------------------------------------------------------------
interface mpu_in_if
    import mpu_pkg::*;
    ();
    logic         valid;
    logic         ready;
    mpu_in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/mpu_out_if.sv
// ----------------------------------------------------------------------------
// mpu_out_if
// Valid/ready channel carrying one result word of the MPU checker.
// ----------------------------------------------------------------------------
interface mpu_out_if
    import mpu_pkg::*;
    ();
    logic          valid;
    logic          ready;
    mpu_out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/mpu_ram.sv
// ----------------------------------------------------------------------------
// mpu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mpu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/mpu_ctrl.sv
// ----------------------------------------------------------------------------
// mpu_ctrl
// Sequencer: accept a word, walk the regions from the top, emit the result.
// ----------------------------------------------------------------------------
module mpu_ctrl
    import mpu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  mpu_status_t status,
    output mpu_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_DONE
    } state_t;

    state_t state_reg;
    logic   in_ready_reg;

    always_comb
    begin
        cmd.capture  = in_ready_reg && in_valid;
        cmd.read     = (state_reg == S_READ);
        cmd.step     = (state_reg == S_EVAL);
        cmd.load_out = (state_reg == S_DONE) && status.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd.capture)
                    begin
                        in_ready_reg <= 1'b0;
                        state_reg    <= status.start_scan ? S_READ : S_DONE;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    if (status.match || status.last_region)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_READ;
                    end
                end
                S_DONE:
                begin
                    if (status.out_free)
                    begin
                        in_ready_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg    <= S_IDLE;
                    in_ready_reg <= 1'b1;
                end
            endcase
        end
    end

    assign in_ready = in_ready_reg;

endmodule

// File: hw/rtl/mpu_dp.sv
// ----------------------------------------------------------------------------
// mpu_dp
// Datapath: control registers, region store, region compare, result stage.
// ----------------------------------------------------------------------------
module mpu_dp
    import mpu_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CTRL_W-1:0]      cfg_data,
    input  mpu_in_word_t           in_word,
    input  mpu_cmd_t               cmd,
    output mpu_status_t            status,
    output logic                   out_valid,
    input  logic                   out_ready,
    output mpu_out_word_t          out_word
);

    logic [CTRL_W-1:0] ctrl_s_reg;
    logic [CTRL_W-1:0] ctrl_ns_reg;
    logic [CTRL_W-1:0] in_ctrl;

    // captured item
    logic              op_reg;
    logic              bank_reg;
    logic [WORD_W-1:0] addr_reg;
    logic              priv_reg;
    logic [1:0]        kind_reg;
    logic              en_reg;
    logic              defmap_reg;

    // scan and hit tracking
    logic [RIDX_W-1:0] idx_reg;
    logic              hit_reg;
    logic [RIDX_W-1:0] hr_reg;
    logic [WORD_W-1:0] mb_reg;
    logic [WORD_W-1:0] ml_reg;

    // region store
    logic [RAM_DEPTH-1:0]  valid_reg;
    logic                  rd_valid_reg;
    logic                  ram_we;
    logic [RAM_AW-1:0]     ram_waddr;
    logic [RAM_AW-1:0]     ram_raddr;
    logic [2*WORD_W-1:0]   ram_rdata;
    logic [WORD_W-1:0]     rd_base;
    logic [WORD_W-1:0]     rd_limit;

    logic [WORD_W-GRAN_LSB-1:0] lo;
    logic [WORD_W-GRAN_LSB-1:0] hi;
    logic [WORD_W-GRAN_LSB-1:0] addr_gran;
    logic                       match;

    logic [1:0]    ap;
    logic          perm;
    logic          allowed;
    logic          out_valid_reg;
    mpu_out_word_t out_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_s_reg  <= '0;
            ctrl_ns_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CTRL_SECURE:    ctrl_s_reg  <= cfg_data;
                REG_CTRL_NONSECURE: ctrl_ns_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    assign in_ctrl = in_word.nonsecure_bank ? ctrl_ns_reg : ctrl_s_reg;

    // region writes go straight into the store at accept
    assign ram_we    = cmd.capture && (in_word.op == OP_WRITE)
                       && (int'(in_word.region_number) < REGION_COUNT);
    assign ram_waddr = RAM_AW'(in_word.nonsecure_bank ? REGION_COUNT : 0)
                       + RAM_AW'(in_word.region_number);
    assign ram_raddr = RAM_AW'(bank_reg ? REGION_COUNT : 0) + RAM_AW'(idx_reg);

    mpu_ram #(
        .WIDTH (2 * WORD_W),
        .DEPTH (RAM_DEPTH)
    ) u_region_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({in_word.limit_word, in_word.base_word}),
        .re    (cmd.read),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // never-written entries read as zero, i.e. disabled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
            if (cmd.read)
            begin
                rd_valid_reg <= valid_reg[ram_raddr];
            end
        end
    end

    assign rd_base  = rd_valid_reg ? ram_rdata[WORD_W-1:0]        : '0;
    assign rd_limit = rd_valid_reg ? ram_rdata[2*WORD_W-1:WORD_W] : '0;

    // granule compare: addr in [lo, hi | 0x1F] <=> lo <= addr[31:5] <= hi
    assign lo        = rd_base[WORD_W-1:GRAN_LSB];
    assign hi        = rd_limit[WORD_W-1:GRAN_LSB];
    assign addr_gran = addr_reg[WORD_W-1:GRAN_LSB];
    assign match     = rd_limit[LIMIT_EN_BIT] && (lo <= hi)
                       && (addr_gran >= lo) && (addr_gran <= hi);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg     <= OP_CHECK;
            en_reg     <= 1'b0;
            hit_reg    <= 1'b0;
        end
        else if (cmd.capture)
        begin
            op_reg  <= in_word.op;
            en_reg  <= in_ctrl[CTRL_ENABLE_BIT];
            hit_reg <= 1'b0;
        end
        else if (cmd.step && match)
        begin
            hit_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            bank_reg   <= in_word.nonsecure_bank;
            addr_reg   <= in_word.address;
            priv_reg   <= in_word.privileged;
            kind_reg   <= in_word.access_kind;
            defmap_reg <= in_ctrl[CTRL_DEFMAP_BIT];
            idx_reg    <= RIDX_W'(REGION_COUNT - 1);
            hr_reg     <= '0;
            mb_reg     <= '0;
            ml_reg     <= '0;
        end
        else if (cmd.step)
        begin
            // scan runs downward, so the first match is the highest one
            if (match)
            begin
                hr_reg <= idx_reg;
                mb_reg <= rd_base;
                ml_reg <= rd_limit;
            end
            else if (idx_reg != '0)
            begin
                idx_reg <= idx_reg - RIDX_W'(1);
            end
        end
    end

    always_comb
    begin
        status.start_scan  = (in_word.op == OP_CHECK) && in_ctrl[CTRL_ENABLE_BIT];
        status.match       = match;
        status.last_region = (idx_reg == '0);
        status.out_free    = !out_valid_reg || out_ready;
    end

    // permission decision
    assign ap = mb_reg[AP_LSB+1:AP_LSB];

    always_comb
    begin
        case (kind_reg)
            KIND_FETCH: perm = !mb_reg[XN_BIT];
            KIND_WRITE: perm = priv_reg ? (ap inside {AP_PRIV_RW, AP_ALL_RW})
                                        : (ap == AP_ALL_RW);
            default:    perm = priv_reg || ap[0];
        endcase
    end

    always_comb
    begin
        if (op_reg == OP_WRITE)
        begin
            allowed = 1'b0;
        end
        else if (!en_reg)
        begin
            allowed = 1'b1;
        end
        else if (hit_reg)
        begin
            allowed = perm;
        end
        else
        begin
            allowed = priv_reg && defmap_reg;
        end
    end

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg.allowed            <= allowed;
            out_reg.unit_enabled       <= (op_reg == OP_CHECK) && en_reg;
            out_reg.region_hit         <= hit_reg;
            out_reg.hit_region         <= 3'(hr_reg);
            out_reg.matched_base_word  <= mb_reg;
            out_reg.matched_limit_word <= ml_reg;
            out_reg.execute_never      <= mb_reg[XN_BIT];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

`ifndef SYNTHESIS
    a_hit_region_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        hit_reg |-> ml_reg[LIMIT_EN_BIT])
        else $error("hit recorded on a disabled region");

    a_hit_region_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        hit_reg |-> (mb_reg[WORD_W-1:GRAN_LSB] <= ml_reg[WORD_W-1:GRAN_LSB]))
        else $error("hit recorded on a region with base above limit");

    a_hit_only_enabled_check: assert property (@(posedge clk) disable iff (!rst_n)
        hit_reg |-> (en_reg && (op_reg == OP_CHECK)))
        else $error("region lookup on a write word or a disabled unit");

    a_hit_covers_address: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && match) |=> (addr_reg[WORD_W-1:GRAN_LSB] >= mb_reg[WORD_W-1:GRAN_LSB]))
        else $error("recorded region does not cover the address");
`endif

endmodule

// File: hw/rtl/mpu_region_access_check.sv
// ----------------------------------------------------------------------------
// mpu_region_access_check
// Memory protection unit, secure and non-secure banks of regions, with
// per-access permission decision.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | word
//  ---------+-----+---------------+------------------------------------------
//  in_ch    | in  | valid/ready   | check or region write (mpu_in_word_t)
//  out_ch   | out | valid/ready   | decision, one per input (mpu_out_word_t)
//  cfg      | in  | cfg_we only   | cfg_index selects ctrl_secure/nonsecure
//
//  Sequence: a region write or a check on a disabled bank goes from accept
//  straight to S_DONE; a check reads 1..REGION_COUNT regions, one at a time
//  through the single read port of the region RAM, S_READ then S_EVAL each.
//  The scan runs from the top region down and stops at the first match.
//  Reset: async active low; clears control registers and the per-entry
//  valid bits, so every region reads as disabled until written.
//  Stalls: a finished result sits in the output register while the next
//  word is accepted; the sequencer waits only while that register is full and out_ready is low.
// ----------------------------------------------------------------------------
module mpu_region_access_check
    import mpu_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    mpu_in_if.sink                 in_ch,
    mpu_out_if.source              out_ch,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CTRL_W-1:0]      cfg_data
);

    mpu_cmd_t      cmd;
    mpu_status_t   status;
    logic          in_ready;
    logic          out_valid;
    mpu_out_word_t out_word;

    // sequencer: owns the handshake on the input side and the scan order
    mpu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: region RAM, compare, decision, output register
    mpu_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_word   (in_ch.data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ch.ready),
        .out_word  (out_word)
    );

    assign in_ch.ready = in_ready;
    assign out_ch.valid = out_valid;
    assign out_ch.data  = out_word;

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the MPU region access checker: a queue-fed driver
// pushes region writes and access checks, a shadow of both region banks
// predicts every decision word, and the monitor compares results in order.
// ----------------------------------------------------------------------------
module tb;
    import mpu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [WORD_W-1:0] GRANULE_LOW  = (1 << GRAN_LSB) - 1;
    localparam logic [WORD_W-1:0] GRANULE_MASK = ~GRANULE_LOW;

    // bank select values as carried in nonsecure_bank
    localparam logic SECURE    = 1'b0;
    localparam logic NONSECURE = 1'b1;

    // encoding 3 is unassigned; the unit treats it as a read
    localparam logic [1:0] KIND_SPARE = 2'd3;

    localparam int PHASES       = 6;
    localparam int PHASE_WORDS  = 215;
    localparam int HOLD_AFTER   = 500;   // results seen before the long stall
    localparam int HOLD_CYCLES  = 200;
    localparam int SETTLE       = 40;    // longer than the worst-case check

    logic clk;
    logic rst_n;

    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CTRL_W-1:0]      cfg_data  = '0;

    mpu_in_if  in_ch ();
    mpu_out_if out_ch ();

    mpu_region_access_check uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    mpu_in_word_t  words_to_send [$];   // filled by the stimulus process
    mpu_out_word_t decisions_due [$];   // predicted at input acceptance

    // Shadow of the unit as seen by accepted words. Index is
    // bank * REGION_COUNT + slot, secure bank first.
    logic [WORD_W-1:0] region_base  [RAM_DEPTH];
    logic [WORD_W-1:0] region_limit [RAM_DEPTH];
    logic [CTRL_W-1:0] bank_ctrl    [2];   // indexed by register index == bank

    // What the stimulus has queued so far; used to aim check addresses
    // at region edges. Runs ahead of the shadow above.
    logic [WORD_W-1:0] plan_base  [RAM_DEPTH];
    logic [WORD_W-1:0] plan_limit [RAM_DEPTH];

    int   mismatch_count = 0;
    int   results_seen;
    int   send_gap;
    int   take_gap;
    int   long_hold;
    logic long_hold_done;
    logic calm_tail = 1'b0;   // no idling on either side once set

    // ------------------------------------------------------------------
    // Clock and reset. Channel inputs get known values at time zero,
    // before the reset branches of the driver and monitor run.
    // ------------------------------------------------------------------
    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard stop; far above the slowest legal run.
    initial
    begin
        #4_000_000;
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    // Applies one accepted word to the shadow and returns its decision.
    // Writes land in the shadow and answer with an all-zero word.
    function automatic mpu_out_word_t predict_decision(input mpu_in_word_t w);
        mpu_out_word_t     d;
        logic [CTRL_W-1:0] ctrl;
        logic [WORD_W-1:0] rb, rl, lo, hi;
        logic [1:0]        ap;
        int                first, i;
        d     = '0;
        first = w.nonsecure_bank ? REGION_COUNT : 0;
        if (w.op == OP_WRITE)
        begin
            if (w.region_number < REGION_COUNT)
            begin
                region_base[first + w.region_number]  = w.base_word;
                region_limit[first + w.region_number] = w.limit_word;
            end
            return d;
        end

        ctrl           = bank_ctrl[w.nonsecure_bank];
        d.unit_enabled = ctrl[CTRL_ENABLE_BIT];
        d.allowed      = 1'b1;
        if (!d.unit_enabled)
            return d;   // disabled bank: everything passes, no lookup

        // ascending scan, so the last match (highest slot) wins
        for (i = 0; i < REGION_COUNT; i++)
        begin
            rb = region_base[first + i];
            rl = region_limit[first + i];
            lo = rb & GRANULE_MASK;
            hi = rl & GRANULE_MASK;
            if (rl[LIMIT_EN_BIT] && lo <= hi &&
                w.address >= lo && w.address <= (hi | GRANULE_LOW))
            begin
                d.region_hit         = 1'b1;
                d.hit_region         = 3'(i);
                d.matched_base_word  = rb;
                d.matched_limit_word = rl;
            end
        end

        if (!d.region_hit)
        begin
            // background map only for privileged code, and only if enabled
            d.allowed = w.privileged && ctrl[CTRL_DEFMAP_BIT];
        end
        else
        begin
            ap              = d.matched_base_word[AP_LSB +: 2];
            d.execute_never = d.matched_base_word[XN_BIT];
            case (w.access_kind)
                KIND_FETCH: d.allowed = !d.execute_never;   // AP ignored
                KIND_WRITE: d.allowed = w.privileged ?
                                        (ap == AP_PRIV_RW || ap == AP_ALL_RW) :
                                        (ap == AP_ALL_RW);
                // read and the spare kind: unprivileged needs AP 01 or 11
                default:    d.allowed = w.privileged || ap[0];
            endcase
        end
        return d;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic flag_mismatch(input string msg);
        $display("%0t ns: MISMATCH %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] got,
                               input logic [WORD_W-1:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task automatic check_decision(input mpu_out_word_t got, input mpu_out_word_t want);
        check_field("allowed", WORD_W'(got.allowed), WORD_W'(want.allowed));
        check_field("unit_enabled", WORD_W'(got.unit_enabled),
                    WORD_W'(want.unit_enabled));
        check_field("region_hit", WORD_W'(got.region_hit), WORD_W'(want.region_hit));
        check_field("hit_region", WORD_W'(got.hit_region), WORD_W'(want.hit_region));
        check_field("matched_base_word",  got.matched_base_word,  want.matched_base_word);
        check_field("matched_limit_word", got.matched_limit_word, want.matched_limit_word);
        check_field("execute_never", WORD_W'(got.execute_never),
                    WORD_W'(want.execute_never));
    endtask

    // ------------------------------------------------------------------
    // Driver: offers queued words, predicts each one as it is accepted.
    // The next word goes up in the same step the current one is taken,
    // so valid stays high across back-to-back words.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
            send_gap    <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                decisions_due.push_back(predict_decision(in_ch.data));
            if (!in_ch.valid || in_ch.ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap    <= send_gap - 1;
                    in_ch.valid <= 1'b0;
                end
                else if (!calm_tail && $urandom_range(0, 7) == 0)
                begin
                    // idle burst, its length drawn into send_gap
                    send_gap    <= $urandom_range(0, 4);
                    in_ch.valid <= 1'b0;
                end
                else if (words_to_send.size() != 0)
                begin
                    in_ch.valid <= 1'b1;
                    in_ch.data  <= words_to_send.pop_front();
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: takes result words, compares with the oldest prediction,
    // and throttles ready in short random bursts.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            take_gap     <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                results_seen <= results_seen + 1;
                if (decisions_due.size() == 0)
                    flag_mismatch("result word with no prediction pending");
                else
                    check_decision(out_ch.data, decisions_due.pop_front());
            end
            if (long_hold != 0)
            begin
                out_ch.ready <= 1'b0;
            end
            else if (take_gap != 0)
            begin
                take_gap     <= take_gap - 1;
                out_ch.ready <= 1'b0;
            end
            else if (!calm_tail && $urandom_range(0, 7) == 0)
            begin
                take_gap     <= $urandom_range(0, 4);
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // One long back-pressure stretch mid-run: the output register fills,
    // the sequencer stalls and in_ch.ready drops while words keep coming.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_hold      <= 0;
            long_hold_done <= 1'b0;
        end
        else if (!long_hold_done && results_seen == HOLD_AFTER)
        begin
            long_hold      <= HOLD_CYCLES;
            long_hold_done <= 1'b1;
        end
        else if (long_hold != 0)
        begin
            long_hold <= long_hold - 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic mpu_in_word_t random_word();
        mpu_in_word_t w;
        w.op             = 1'($urandom);
        w.nonsecure_bank = 1'($urandom);
        w.address        = $urandom;
        w.privileged     = 1'($urandom);
        w.access_kind    = 2'($urandom);
        w.region_number  = 3'($urandom);
        w.base_word      = $urandom;
        w.limit_word     = $urandom;
        return w;
    endfunction

    // Unused fields of each word stay random so every bit toggles.
    task automatic queue_write(input logic bank, input logic [2:0] slot,
                               input logic [WORD_W-1:0] base,
                               input logic [WORD_W-1:0] limit);
        mpu_in_word_t w;
        w                = random_word();
        w.op             = OP_WRITE;
        w.nonsecure_bank = bank;
        w.region_number  = slot;
        w.base_word      = base;
        w.limit_word     = limit;
        words_to_send.push_back(w);
        if (slot < REGION_COUNT)
        begin
            plan_base[bank * REGION_COUNT + slot]  = base;
            plan_limit[bank * REGION_COUNT + slot] = limit;
        end
    endtask

    task automatic queue_check(input logic bank, input logic [WORD_W-1:0] addr,
                               input logic priv, input logic [1:0] kind);
        mpu_in_word_t w;
        w                = random_word();
        w.op             = OP_CHECK;
        w.nonsecure_bank = bank;
        w.address        = addr;
        w.privileged     = priv;
        w.access_kind    = kind;
        words_to_send.push_back(w);
    endtask

    // Aim at a planned region: its edges, one past each edge, or inside; sometimes anywhere.
    function automatic logic [WORD_W-1:0] pick_address(input logic bank);
        logic [WORD_W-1:0] lo, top;
        logic [63:0]       span;
        int                idx;
        idx = bank * REGION_COUNT + $urandom_range(0, REGION_COUNT - 1);
        lo  = plan_base[idx] & GRANULE_MASK;
        top = plan_limit[idx] | GRANULE_LOW;
        case ($urandom_range(0, 7))
            0:       return lo;
            1:       return top;
            2:       return lo - 1;
            3:       return top + 1;
            7:       return $urandom;
            default:
            begin
                if (lo > top)
                    return $urandom;
                span = 64'(top) - 64'(lo) + 64'd1;
                return lo + WORD_W'(64'($urandom) % span);
            end
        endcase
    endfunction

    // Regions cluster in three 4 KB windows so they overlap often; some
    // land anywhere, some are inverted (base above limit), a few disabled.
    task automatic queue_random_write();
        logic [WORD_W-1:0] lo, hi, tmp;
        logic [WORD_W-1:0] base, limit;
        int                zone;
        lo   = $urandom;
        zone = $urandom_range(0, 3);
        if (zone != 3)
            lo[31:12] = 20'(zone);
        if ($urandom_range(0, 7) == 0)
            hi = $urandom;
        else
            hi = lo + WORD_W'($urandom_range(0, 40)) * 32;
        if ($urandom_range(0, 9) == 0)
        begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
        end
        base          = {lo[31:5], 5'($urandom)};
        limit         = {hi[31:5], 5'($urandom)};
        limit[LIMIT_EN_BIT] = ($urandom_range(0, 6) != 0);
        queue_write(1'($urandom), 3'($urandom), base, limit);
    endtask

    task automatic queue_random_word();
        logic bank;
        bank = 1'($urandom);
        if ($urandom_range(0, 4) == 0)
            queue_random_write();
        else if ($urandom_range(0, 9) == 0)
            queue_check(bank, $urandom, 1'($urandom), 2'($urandom));
        else
            queue_check(bank, pick_address(bank), 1'($urandom), 2'($urandom));
    endtask

    // Control writes happen only with nothing in flight.
    task automatic write_ctrl(input logic [CFG_INDEX_W-1:0] idx,
                              input logic [CTRL_W-1:0] val);
        @(posedge clk);
        cfg_we         <= 1'b1;
        cfg_index      <= idx;
        cfg_data       <= val;
        bank_ctrl[idx]  = val;
        @(posedge clk);
        cfg_we         <= 1'b0;
    endtask

    task automatic wait_idle();
        while (words_to_send.size() != 0 || in_ch.valid || decisions_due.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [CTRL_W-1:0] phase_ctrl [PHASES][2];
        int                p, n;

        // secure / non-secure control per random phase; all-off and
        // all-on settings included, bit1 toggled for no effect
        phase_ctrl = '{'{3'd1, 3'd1}, '{3'd5, 3'd4}, '{3'd0, 3'd7},
                       '{3'd7, 3'd0}, '{3'd3, 3'd6}, '{3'd7, 3'd7}};

        for (n = 0; n < RAM_DEPTH; n++)
        begin
            region_base[n]  = '0;
            region_limit[n] = '0;
            plan_base[n]    = '0;
            plan_limit[n]   = '0;
        end
        bank_ctrl[0] = '0;
        bank_ctrl[1] = '0;

        wait (rst_n === 1'b1);
        write_ctrl(REG_CTRL_SECURE, 3'd7);
        write_ctrl(REG_CTRL_NONSECURE, 3'd7);

        @(negedge clk);
        // empty banks: background map decides
        queue_check(SECURE,    32'h0000_0000, 1'b1, KIND_READ);
        queue_check(SECURE,    32'h8000_0000, 1'b0, KIND_READ);
        // secure: full-space AP01 region under a small AP11+XN region,
        // and a one-granule-plus AP10 region
        queue_write(SECURE,    3'd0, 32'h0000_0002, 32'hFFFF_FFE1);
        queue_write(SECURE,    3'd7, 32'h1000_0007, 32'h1000_0FE1);
        queue_write(SECURE,    3'd2, 32'h2000_0004, 32'h2000_0021);
        // non-secure: top granule AP00, an inverted region, a disabled one
        queue_write(NONSECURE, 3'd3, 32'hFFFF_FFE0, 32'hFFFF_FFFF);
        queue_write(NONSECURE, 3'd5, 32'h2000_0040, 32'h2000_0001);
        queue_write(NONSECURE, 3'd6, 32'h0000_0000, 32'hFFFF_FFE0);
        queue_check(SECURE,    32'hFFFF_FFFF, 1'b0, KIND_WRITE);
        queue_check(SECURE,    32'h1000_0000, 1'b0, KIND_WRITE);
        queue_check(SECURE,    32'h1000_0FFF, 1'b0, KIND_READ);
        queue_check(SECURE,    32'h1000_0800, 1'b1, KIND_FETCH);
        queue_check(SECURE,    32'h1000_1000, 1'b1, KIND_FETCH);
        queue_check(SECURE,    32'h1000_0010, 1'b0, KIND_SPARE);
        queue_check(SECURE,    32'h1000_0020, 1'b1, KIND_WRITE);
        queue_check(SECURE,    32'h0FFF_FFFF, 1'b0, KIND_READ);
        queue_check(SECURE,    32'h2000_003F, 1'b0, KIND_READ);
        queue_check(SECURE,    32'h2000_0000, 1'b1, KIND_READ);
        queue_check(SECURE,    32'h2000_0020, 1'b1, KIND_WRITE);
        queue_check(NONSECURE, 32'hFFFF_FFFF, 1'b0, KIND_READ);
        queue_check(NONSECURE, 32'hFFFF_FFE0, 1'b1, KIND_WRITE);
        queue_check(NONSECURE, 32'hFFFF_FFDF, 1'b1, KIND_READ);
        queue_check(NONSECURE, 32'h2000_0040, 1'b0, KIND_FETCH);
        queue_check(NONSECURE, 32'h0000_0000, 1'b1, KIND_FETCH);
        wait_idle();

        // random phases; the long output stall lands in the third
        for (p = 0; p < PHASES; p++)
        begin
            write_ctrl(REG_CTRL_SECURE,    phase_ctrl[p][0]);
            write_ctrl(REG_CTRL_NONSECURE, phase_ctrl[p][1]);
            if (p == PHASES - 1)
                calm_tail <= 1'b1;   // last phase at full rate
            @(negedge clk);
            for (n = 0; n < PHASE_WORDS; n++)
                queue_random_word();
            wait_idle();
        end

        repeat (SETTLE) @(posedge clk);
        if (decisions_due.size() != 0)
            flag_mismatch($sformatf("%0d predicted results never arrived",
                                    decisions_due.size()));
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
